FILE: src/lcgrng_pkg.sv
// ----------------------------------------------------------------------------
// lcgrng_pkg
// shared types and constants of the entropy-mixed ranged lcg generator
// ----------------------------------------------------------------------------
package lcgrng_pkg;

  localparam logic [63:0] LCG_MULT   = 64'd6364136223846793005;
  localparam logic [63:0] LCG_INC    = 64'd1442695040888963407;
  localparam logic [31:0] SMALL_SPAN = 32'h0001_0000;
  localparam int          HALF_BITS  = 32;

  // request kinds as carried on in_tuser
  localparam logic [1:0] KIND_DRAW32 = 2'd0;
  localparam logic [1:0] KIND_DRAW64 = 2'd1;
  localparam logic [1:0] KIND_RANGED = 2'd2;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_FIXED,    // no draw, value is the base
    OP_ONE,      // one draw, upper seed half
    OP_TWO,      // two draws, high word first
    OP_RNG_ONE,  // one draw reduced by the span
    OP_RNG_TWO   // two draws reduced by the span
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] e1;
    logic [63:0] e2;
    logic [31:0] span;
    logic [31:0] base;
  } cmd_t;

endpackage

FILE: src/lcg_entropy_ranged_rng.sv
// ----------------------------------------------------------------------------
// lcg_entropy_ranged_rng
// 64-bit lcg generator with entropy mixing and ranged draws
// ----------------------------------------------------------------------------
// requests arrive on the in_ stream: in_tuser carries the kind (32-bit draw,
// 64-bit draw, ranged draw), in_tdata the two entropy words and the bounds.
// each request gives exactly one word on the out_ stream, in request order.
// a decoder puts requests into a two-entry queue, so up to two further
// requests are taken while the sequencer works or a result waits.
// each draw steps through S_MUL_LO, S_MUL_X1 and S_MUL_X2 on the shared
// 32x32 multiplier. equal bounds and an unused kind need no draw, a 32-bit
// draw needs one and a 64-bit draw two; a ranged draw over a span below 65536
// takes one draw and a 32-bit remainder, a wider span two draws and a 64-bit
// remainder, the remainder being worked out one bit a cycle. the sequencer
// goes back to idle once the result is taken, and only then pops the queue.
// reset clears the seed to zero and empties the queue and the output.
// while out_tready is low the result holds in the output register and the
// sequencer waits; the input side stalls once the queue is full.
// ----------------------------------------------------------------------------
module lcg_entropy_ranged_rng (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // entropy_first, entropy_second, range_low, range_high
  input  logic [191:0] in_tdata,
  // kind
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // value
  output logic [63:0]  out_tdata
);
  import lcgrng_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  lcgrng_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  lcgrng_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  lcgrng_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: src/lcgrng_front.sv
// ----------------------------------------------------------------------------
// lcgrng_front
// decodes a request word into an operation, span and base for the back end
// ----------------------------------------------------------------------------
module lcgrng_front (
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [191:0]        in_tdata,
  input  logic [1:0]          in_tuser,
  input  logic                q_full,
  output logic                q_push,
  output lcgrng_pkg::cmd_t    q_cmd
);
  import lcgrng_pkg::*;

  logic [31:0] lo;
  logic [31:0] hi;
  logic [31:0] span;

  assign lo = in_tdata[159:128];
  assign hi = in_tdata[191:160];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    span       = 32'd0;
    q_cmd.op   = OP_FIXED;
    q_cmd.e1   = in_tdata[63:0];
    q_cmd.e2   = in_tdata[127:64];
    q_cmd.span = 32'd0;
    q_cmd.base = 32'd0;
    unique case (in_tuser)
      KIND_DRAW32: q_cmd.op = OP_ONE;
      KIND_DRAW64: q_cmd.op = OP_TWO;
      KIND_RANGED: begin
        if (lo == hi) begin
          q_cmd.base = lo;
        end else begin
          if (lo < hi) begin
            span       = hi - lo;
            q_cmd.base = lo;
          end else begin
            // open below, closed above
            span       = lo - hi;
            q_cmd.base = hi + 32'd1;
          end
          q_cmd.span = span;
          q_cmd.op   = (span < SMALL_SPAN) ? OP_RNG_ONE : OP_RNG_TWO;
        end
      end
      default: q_cmd.op = OP_FIXED;
    endcase
  end

endmodule

FILE: src/lcgrng_queue.sv
// ----------------------------------------------------------------------------
// lcgrng_queue
// short request queue decoupling the decoder from the draw sequencer
// ----------------------------------------------------------------------------
module lcgrng_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lcgrng_pkg::cmd_t  push_cmd,
  output logic              full,
  input  logic              pop,
  output lcgrng_pkg::cmd_t  pop_cmd,
  output logic              empty
);
  import lcgrng_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: src/lcgrng_back.sv
// ----------------------------------------------------------------------------
// lcgrng_back
// draw sequencer: seed update on a shared 32x32 multiplier, bit-serial
// remainder by the span, and the result register
// ----------------------------------------------------------------------------
module lcgrng_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  lcgrng_pkg::cmd_t  q_cmd,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata
);
  import lcgrng_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_X1,
    S_MUL_X2,
    S_DIV,
    S_OUT
  } state_t;

  state_t      state_r;
  logic [63:0] seed_r;
  logic [63:0] a_r;
  logic [63:0] p_r;
  logic [31:0] hi_r;
  logic        second_r;
  cmd_t        cmd_r;
  logic [63:0] val_r;
  logic [63:0] dvd_r;
  logic [31:0] rem_r;
  logic [6:0]  cnt_r;
  logic        out_valid_r;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] seed_nxt;
  logic [31:0] draw;
  logic [32:0] trial;
  logic [32:0] trial_sub;
  logic [31:0] rem_nxt;

  // one multiplier shared over the three partial products
  always_comb begin
    mul_a = a_r[31:0];
    mul_b = LCG_MULT[31:0];
    case (state_r)
      S_MUL_X1: begin
        mul_a = a_r[63:32];
        mul_b = LCG_MULT[31:0];
      end
      S_MUL_X2: begin
        mul_a = a_r[31:0];
        mul_b = LCG_MULT[63:32];
      end
      default: ;
    endcase
  end

  assign prod     = {32'd0, mul_a} * {32'd0, mul_b};
  assign seed_nxt = {hi_r + prod[31:0], p_r[31:0]} + LCG_INC;
  assign draw     = seed_nxt[63:HALF_BITS];

  // one restoring remainder step a cycle
  assign trial     = {rem_r, dvd_r[63]};
  assign trial_sub = trial - {1'b0, cmd_r.span};
  assign rem_nxt   = (trial >= {1'b0, cmd_r.span}) ? trial_sub[31:0] : trial[31:0];

  assign q_pop      = (state_r == S_IDLE) && !q_empty;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seed_r      <= 64'd0;
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
      cnt_r       <= 7'd0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r    <= q_cmd;
            second_r <= 1'b0;
            if (q_cmd.op == OP_FIXED) begin
              val_r       <= {32'd0, q_cmd.base};
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              a_r     <= seed_r ^ q_cmd.e1;
              state_r <= S_MUL_LO;
            end
          end
        end
        S_MUL_LO: begin
          p_r     <= prod;
          state_r <= S_MUL_X1;
        end
        S_MUL_X1: begin
          hi_r    <= p_r[63:32] + prod[31:0];
          state_r <= S_MUL_X2;
        end
        S_MUL_X2: begin
          seed_r <= seed_nxt;
          if ((cmd_r.op == OP_TWO || cmd_r.op == OP_RNG_TWO) && !second_r) begin
            // first draw is the high word
            val_r[63:32] <= draw;
            second_r     <= 1'b1;
            a_r          <= seed_nxt ^ cmd_r.e2;
            state_r      <= S_MUL_LO;
          end else begin
            unique case (cmd_r.op)
              OP_ONE: begin
                val_r       <= {32'd0, draw};
                out_valid_r <= 1'b1;
                state_r     <= S_OUT;
              end
              OP_TWO: begin
                val_r[31:0] <= draw;
                out_valid_r <= 1'b1;
                state_r     <= S_OUT;
              end
              OP_RNG_ONE: begin
                dvd_r   <= {draw, 32'd0};
                rem_r   <= 32'd0;
                cnt_r   <= 7'd32;
                state_r <= S_DIV;
              end
              default: begin
                dvd_r   <= {val_r[63:32], draw};
                rem_r   <= 32'd0;
                cnt_r   <= 7'd64;
                state_r <= S_DIV;
              end
            endcase
          end
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          dvd_r <= {dvd_r[62:0], 1'b0};
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            val_r       <= {32'd0, cmd_r.base + rem_nxt};
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the entropy-mixed ranged lcg generator
// ----------------------------------------------------------------------------
// the bench first walks a short table of requests: extreme entropy words,
// every kind, equal bounds, spans of one, spans either side of 65536 and
// the unused kind. it then sends random requests, mostly ranged, with spans
// mostly below 65536, some at that boundary, wider or zero. a behavioural
// model of the seed predicts each word. both stream sides idle at random,
// and now and then the sender waits until the output has drained.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lcgrng_pkg::*;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         RANDOM_ITEMS = 1600;
  localparam int         MAX_GAP      = 17;
  localparam int         DRAIN_CYCLES = 80;
  localparam int         REPORT_LIMIT = 10;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] entropy_first;
    logic [63:0] entropy_second;
    logic [31:0] range_low;
    logic [31:0] range_high;
    bit          known;
    logic [63:0] value;
  } request_row_t;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // entropy_first, entropy_second, range_low, range_high
  logic [191:0] in_tdata = '0;
  // kind
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // value
  logic [63:0]  out_tdata;

  logic [63:0]  lcg_seed;
  logic [63:0]  expected_values[$];
  int           mismatches;
  bit           sender_burst;
  bit           receiver_burst;

  lcg_entropy_ranged_rng dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // one lcg step with the entropy word folded in, upper half returned
  function automatic logic [31:0] mix_and_step(input logic [63:0] entropy);
    logic [63:0] mixed;
    mixed = (lcg_seed ^ entropy) * LCG_MULT + LCG_INC;
    lcg_seed = mixed;
    return mixed[63:32];
  endfunction

  function automatic logic [63:0] draw_pair(input logic [63:0] e_hi,
                                            input logic [63:0] e_lo);
    logic [31:0] hi_word;
    logic [31:0] lo_word;
    hi_word = mix_and_step(e_hi);
    lo_word = mix_and_step(e_lo);
    return {hi_word, lo_word};
  endfunction

  function automatic logic [63:0] predict_value(input logic [1:0]  kind,
                                                input logic [63:0] e1,
                                                input logic [63:0] e2,
                                                input logic [31:0] lo,
                                                input logic [31:0] hi);
    logic [31:0] span;
    logic [31:0] base;
    logic [31:0] offset;
    logic [63:0] wide;
    predict_value = 64'd0;
    case (kind)
      KIND_DRAW32: predict_value = {32'd0, mix_and_step(e1)};
      KIND_DRAW64: predict_value = draw_pair(e1, e2);
      KIND_RANGED: begin
        if (lo == hi) begin
          predict_value = {32'd0, lo};
        end else begin
          // reversed bounds give a result in (high, low]
          if (lo < hi) begin
            span = hi - lo;
            base = lo;
          end else begin
            span = lo - hi;
            base = hi + 32'd1;
          end
          if (span < SMALL_SPAN) begin
            offset = mix_and_step(e1) % span;
          end else begin
            wide   = draw_pair(e1, e2) % {32'd0, span};
            offset = wide[31:0];
          end
          predict_value = {32'd0, base + offset};
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] random_entropy();
    case ($urandom_range(0, 15))
      0:       return 64'd0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    if (mismatches < REPORT_LIMIT)
      $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    mismatches++;
  endtask

  // drive one request and hold it until the word is taken
  task automatic send_request(input logic [1:0]  kind,
                              input logic [63:0] e1,
                              input logic [63:0] e2,
                              input logic [31:0] lo,
                              input logic [31:0] hi,
                              input bit          known,
                              input logic [63:0] value);
    int          gap;
    logic [63:0] predicted;
    gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {hi, lo, e2, e1};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_value(kind, e1, e2, lo, hi);
    expected_values.push_back(known ? value : predicted);
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_values.size() != 0);
  endtask

  // result side: random stall before each word, checked on acceptance
  initial begin
    int          stall;
    logic [63:0] want;
    mismatches     = 0;
    receiver_burst = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) receiver_burst = !receiver_burst;
      stall = receiver_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      if (expected_values.size() == 0) begin
        report_mismatch("word with no request waiting", 64'd0, out_tdata);
      end else begin
        want = expected_values.pop_front();
        if (out_tdata !== want) report_mismatch("value", want, out_tdata);
      end
    end
  end

  initial begin
    #15ms;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    request_row_t directed_rows[$];
    request_row_t row;
    int           counted;
    logic [1:0]   kind;
    logic [31:0]  lo;
    logic [31:0]  hi;
    logic [31:0]  span;
    int           pick;

    lcg_seed     = 64'd0;
    sender_burst = 1'b0;

    // first row relies on the seed being zero after reset
    directed_rows.push_back('{KIND_DRAW32, 64'd0, 64'd0, 32'd0, 32'd0,
                              1'b1, 64'h0000_0000_1405_7b7e});
    directed_rows.push_back('{KIND_DRAW32, '1, 64'd0, 32'd0, 32'd0, 1'b0, 64'd0});
    directed_rows.push_back('{KIND_DRAW64, 64'd0, '1, '1, '1, 1'b0, 64'd0});
    directed_rows.push_back('{KIND_DRAW64, '1, 64'd0, 32'd0, 32'd0, 1'b0, 64'd0});
    directed_rows.push_back('{KIND_DRAW64, '1, '1, '1, '1, 1'b0, 64'd0});
    // equal bounds: no draw, the bound comes straight back
    directed_rows.push_back('{KIND_RANGED, '1, '1, 32'd0, 32'd0, 1'b1, 64'd0});
    directed_rows.push_back('{KIND_RANGED, 64'd0, 64'd0, '1, '1,
                              1'b1, 64'h0000_0000_ffff_ffff});
    directed_rows.push_back('{KIND_RANGED, {$urandom, $urandom}, {$urandom, $urandom},
                              32'h1234_5678, 32'h1234_5678,
                              1'b1, 64'h0000_0000_1234_5678});
    // spans of one still consume a draw but the offset is always zero
    directed_rows.push_back('{KIND_RANGED, random_entropy(), 64'd0, 32'd0, 32'd1,
                              1'b1, 64'd0});
    directed_rows.push_back('{KIND_RANGED, random_entropy(), 64'd0, 32'd1, 32'd0,
                              1'b1, 64'd1});
    directed_rows.push_back('{KIND_RANGED, random_entropy(), 64'd0,
                              32'hffff_ffff, 32'hffff_fffe,
                              1'b1, 64'h0000_0000_ffff_ffff});
    directed_rows.push_back('{KIND_RANGED, random_entropy(), 64'd0,
                              32'hffff_fffe, 32'hffff_ffff,
                              1'b1, 64'h0000_0000_ffff_fffe});
    // either side of the one-draw limit, both orders
    directed_rows.push_back('{KIND_RANGED, random_entropy(), random_entropy(),
                              32'd0, 32'h0000_ffff, 1'b0, 64'd0});
    directed_rows.push_back('{KIND_RANGED, random_entropy(), random_entropy(),
                              32'd0, 32'h0001_0000, 1'b0, 64'd0});
    directed_rows.push_back('{KIND_RANGED, random_entropy(), random_entropy(),
                              32'h0000_ffff, 32'd0, 1'b0, 64'd0});
    directed_rows.push_back('{KIND_RANGED, random_entropy(), random_entropy(),
                              32'h0001_0000, 32'd0, 1'b0, 64'd0});
    directed_rows.push_back('{KIND_RANGED, '1, '1, 32'd0, '1, 1'b0, 64'd0});
    directed_rows.push_back('{KIND_RANGED, 64'd0, '1, '1, 32'd0, 1'b0, 64'd0});
    // unused kind leaves the seed alone and returns zero
    directed_rows.push_back('{KIND_UNUSED, '1, '1, '1, '1, 1'b1, 64'd0});
    directed_rows.push_back('{KIND_UNUSED, 64'd0, 64'd0, 32'd0, 32'd0, 1'b1, 64'd0});
    directed_rows.push_back('{KIND_DRAW32, {$urandom, $urandom}, 64'd0, 32'd0, 32'd0,
                              1'b0, 64'd0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.kind, row.entropy_first, row.entropy_second,
                   row.range_low, row.range_high, row.known, row.value);
    end
    wait_for_drain();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(0, 47) == 0) sender_burst = !sender_burst;
      pick = $urandom_range(0, 19);
      if (pick == 0)      kind = KIND_UNUSED;
      else if (pick <= 4) kind = KIND_DRAW32;
      else if (pick <= 8) kind = KIND_DRAW64;
      else                kind = KIND_RANGED;

      lo = $urandom;
      case ($urandom_range(0, 9))
        0:       span = 32'd0;
        1:       span = $urandom_range(0, 1) ? 32'h0000_ffff : 32'h0001_0000;
        2, 3:    span = $urandom;
        default: span = $urandom_range(1, 32'h0000_ffff);
      endcase
      if ($urandom_range(0, 1)) begin
        hi = lo + span;
      end else begin
        hi = lo;
        lo = lo + span;
      end

      send_request(kind, random_entropy(), random_entropy(), lo, hi, 1'b0, 64'd0);
      if (kind != KIND_UNUSED) counted++;
      if (counted == RANDOM_ITEMS / 2 && kind != KIND_UNUSED) wait_for_drain();
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_values.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
